// ===== rtl/wmc_pkg.sv =====
// wmc_pkg: shared types and constants of the watermark min combiner
// no dependencies
package wmc_pkg;

  localparam int unsigned TimeW = 64;

  localparam logic signed [TimeW-1:0] TIME_MIN = {1'b1, {(TimeW-1){1'b0}}};
  localparam logic signed [TimeW-1:0] TIME_MAX = {1'b0, {(TimeW-1){1'b1}}};

  // one stored entry per stream input
  typedef struct packed {
    logic                    idle;
    logic signed [TimeW-1:0] tstamp;
  } wmc_entry_t;

  // running result of the minimum scan
  typedef struct packed {
    logic                    all_idle;
    logic signed [TimeW-1:0] lowest;
  } wmc_scan_t;

endpackage

// ===== rtl/wmc_mem.sv =====
// wmc_mem: per-input entry store, one write and one registered read port
// depends on wmc_pkg; entries never written read back as active, most negative time
module wmc_mem import wmc_pkg::*; #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  wmc_entry_t       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output wmc_entry_t       rdata_o
);

  wmc_entry_t           mem [Depth];
  wmc_entry_t           rdata_q;
  logic [Depth-1:0]     written_q;
  logic                 rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  // written flags stand in for clearing the array after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= written_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? rdata_q : wmc_entry_t'{idle: 1'b0, tstamp: TIME_MIN};

endmodule

// ===== rtl/wmc_scan.sv =====
// wmc_scan: running minimum over the active entries, one entry per cycle while en_i is high
// depends on wmc_pkg
module wmc_scan import wmc_pkg::*; #(
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             clear_i,
  input  logic             en_i,
  input  wmc_entry_t       entry_i,
  input  logic [AddrW-1:0] addr_i,
  output wmc_scan_t        result_o,
  output logic [AddrW-1:0] holder_o
);

  wmc_scan_t        acc_q, acc_d;
  logic [AddrW-1:0] holder_q, holder_d;

  always_comb begin
    acc_d    = acc_q;
    holder_d = holder_q;
    if (clear_i) begin
      acc_d    = '{all_idle: 1'b1, lowest: TIME_MAX};
      holder_d = '0;
    end else if (en_i && !entry_i.idle) begin
      acc_d.all_idle = 1'b0;
      // strict less keeps the lowest-numbered input on ties
      if ($signed(entry_i.tstamp) < $signed(acc_q.lowest)) begin
        acc_d.lowest = entry_i.tstamp;
        holder_d     = addr_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    holder_q <= holder_d;
  end

  assign result_o = acc_q;
  assign holder_o = holder_q;

endmodule

// ===== rtl/watermark_min_combiner.sv =====
// watermark_min_combiner: merges per-input watermarks into one monotonic watermark
// depends on wmc_pkg, wmc_mem, wmc_scan
//
//  channel   | signals                                       | handshake
//  ----------+-----------------------------------------------+--------------------------
//  update in | input_index_i, new_idle_i, new_timestamp_i    | start high, busy low
//  result    | combined_idle_o, combined_time_o,             | result_valid_o, one cycle
//            | lowest_input_o, bad_index_o                   | no back-pressure
//
// a bad index is answered straight from the done register, an update that needs no
// recompute after the update state; a recompute walks the entry memory one read a
// cycle through the scan, drain and final states before the word is registered
// for a valid index busy stays high until the word is on the outputs; a new
// start may come in the cycle the word strobes
// reset leaves every input active at the most negative time, held by written flags
module watermark_min_combiner import wmc_pkg::*; #(
  parameter int unsigned NUM_INPUTS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic [3:0]              input_index_i,
  input  logic                    new_idle_i,
  input  logic signed [TimeW-1:0] new_timestamp_i,
  output logic                    result_valid_o,
  output logic                    combined_idle_o,
  output logic signed [TimeW-1:0] combined_time_o,
  output logic [3:0]              lowest_input_o,
  output logic                    bad_index_o
);

  localparam int unsigned IdxW = (NUM_INPUTS > 1) ? $clog2(NUM_INPUTS) : 1;
  localparam int unsigned ExtW = ((IdxW > 4) ? IdxW : 4) + 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_INPUTS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_UPD   = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [IdxW-1:0]         cnt_q, cnt_d;
  logic                    acc_en_q;
  logic [IdxW-1:0]         acc_addr_q;
  logic [IdxW-1:0]         addr_q;
  logic                    idle_q;
  logic signed [TimeW-1:0] ts_q;

  logic                    out_idle_q;
  logic signed [TimeW-1:0] out_time_q;
  logic [IdxW-1:0]         holder_q;
  logic                    bad_q;
  logic                    done_q;

  logic [ExtW-1:0]         idx_ext;
  logic                    accept;
  logic                    bad_in;

  logic                    mem_we;
  wmc_entry_t              mem_wdata;
  logic                    mem_re;
  logic [IdxW-1:0]         mem_raddr;
  wmc_entry_t              mem_rdata;

  logic                    advance;
  logic                    again;
  logic                    scan_clear;
  wmc_scan_t               scan_res;
  logic [IdxW-1:0]         scan_holder;

  assign idx_ext = ExtW'(input_index_i);
  assign bad_in  = idx_ext >= ExtW'(NUM_INPUTS);
  assign accept  = start && !busy;
  assign busy    = state_q != S_IDLE;

  // read-modify-write of the addressed entry
  assign advance   = $signed(mem_rdata.tstamp) < $signed(ts_q);
  assign again     = (mem_rdata.idle != idle_q) || (advance && (addr_q == holder_q));
  assign mem_we    = state_q == S_UPD;
  assign mem_wdata = '{idle: idle_q, tstamp: advance ? ts_q : mem_rdata.tstamp};

  // the write lands before the first scan read, so no forwarding is needed
  assign mem_re    = accept || (state_q == S_SCAN);
  assign mem_raddr = (state_q == S_SCAN) ? cnt_q : idx_ext[IdxW-1:0];

  assign scan_clear = (state_q == S_UPD) && again;

  wmc_mem #(
    .Depth (NUM_INPUTS),
    .AddrW (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (addr_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  wmc_scan #(
    .AddrW (IdxW)
  ) u_scan (
    .clk_i    (clk_i),
    .clear_i  (scan_clear),
    .en_i     (acc_en_q),
    .entry_i  (mem_rdata),
    .addr_i   (acc_addr_q),
    .result_o (scan_res),
    .holder_o (scan_holder)
  );

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (accept && !bad_in) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        cnt_d   = '0;
        state_d = again ? S_SCAN : S_IDLE;
      end
      S_SCAN: begin
        if (cnt_q == LastIdx) begin
          state_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_DRAIN: state_d = S_FIN;
      S_FIN:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      acc_en_q   <= 1'b0;
      done_q     <= 1'b0;
      out_idle_q <= 1'b0;
      out_time_q <= TIME_MIN;
      holder_q   <= '0;
      bad_q      <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      acc_en_q <= state_q == S_SCAN;
      done_q   <= (accept && bad_in) || ((state_q == S_UPD) && !again) ||
                  (state_q == S_FIN);
      if (accept) begin
        bad_q <= bad_in;
      end
      if (state_q == S_FIN) begin
        if (scan_res.all_idle) begin
          out_idle_q <= 1'b1;
        end else begin
          out_idle_q <= 1'b0;
          holder_q   <= scan_holder;
          // combined time only moves forward
          if ($signed(out_time_q) <= $signed(scan_res.lowest)) begin
            out_time_q <= scan_res.lowest;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_addr_q <= cnt_q;
    if (accept) begin
      addr_q <= idx_ext[IdxW-1:0];
      idle_q <= new_idle_i;
      ts_q   <= new_timestamp_i;
    end
  end

  assign result_valid_o  = done_q;
  assign combined_idle_o = out_idle_q;
  assign combined_time_o = out_time_q;
  assign lowest_input_o  = 4'(holder_q);
  assign bad_index_o     = bad_q;

  // a word is only presented once the sequencer is back at rest
  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result word strobed while busy");

  // a bad index is answered in the next cycle and flagged
  a_bad_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && bad_in) |=> (result_valid_o && bad_index_o))
    else $error("bad index not answered in the next cycle");

  // the combined watermark never moves backward
  a_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $signed(combined_time_o) >= $signed($past(combined_time_o)))
    else $error("combined time moved backward");

endmodule
